// File: hw/rtl/modbus_rtu_register_slave_macros.svh
// assertion macros for the modbus rtu register slave
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrs assertion failed");

// next-cycle implication, disabled while in reset
`define MRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrs assertion failed");

`endif

// File: hw/rtl/mrs_pkg.sv
// types, codes and helpers for the modbus rtu register slave
package mrs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CRC
  } state_t;

  localparam logic [7:0]  FN_READ    = 8'h03;
  localparam logic [7:0]  FN_WRITE   = 8'h10;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  TGT_A      = 8'h04;
  localparam logic [7:0]  TGT_B      = 8'h05;
  localparam logic [7:0]  TGT_C      = 8'h10;
  localparam logic [7:0]  TGT_D      = 8'h11;
  localparam int          SHORT_LEN  = 8;
  localparam int          LONG_LEN   = 11;
  localparam int          FRAME_KEEP = 9;
  localparam logic [7:0]  WRITE_DATA = 8'd6;
  localparam int          NUM_SLOTS  = 4;

  // register index is one of the four writable ones
  function automatic logic is_target(input logic [7:0] idx);
    return (idx == TGT_A) || (idx == TGT_B) || (idx == TGT_C) || (idx == TGT_D);
  endfunction

  // writable registers 4, 5, 16, 17 map onto slots by bits 4 and 0
  function automatic logic [1:0] slot_of(input logic [7:0] idx);
    return {idx[4], idx[0]};
  endfunction

endpackage

// File: hw/rtl/modbus_rtu_register_slave.sv
// modbus rtu holding-register slave: frame capture, reply sequencer, bit-serial crc
// input bytes are accepted only while no reply is being built; a frame completes on its
// last byte. each reply data byte is one load step and eight crc shift steps, the two crc
// bytes one load step each: a read reply is 2*NUM_REGS+5 bytes, a write echo 8.
// the output register lets the next byte be built while the current one waits.
// synchronous active-low reset: slave address 1, registers zero, crc 0xffff, idle.
`include "modbus_rtu_register_slave_macros.svh"

module modbus_rtu_register_slave #(
  parameter int NUM_REGS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_last_byte
);
  import mrs_pkg::*;

  localparam logic [7:0] BYTE_CNT  = 8'((2 * NUM_REGS) % 256);
  localparam logic [7:0] READ_DATA = 8'(2 * NUM_REGS + 3);

  state_t      state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  frame_r [FRAME_KEEP];
  logic [7:0]  frame_nxt [FRAME_KEEP];
  logic [15:0] hreg_r [NUM_SLOTS];
  logic [15:0] hreg_nxt [NUM_SLOTS];
  logic [7:0]  slave_r, slave_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  k_r, k_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        in_xfer;
  logic [3:0]  cnt_inc;
  logic        frame_done;
  logic        addr_ok;
  logic        start_read;
  logic        start_write;
  logic        slot_free;
  logic [7:0]  n_data;
  logic [7:0]  data_byte;
  logic [7:0]  j;
  logic [7:0]  reg_idx;
  logic [15:0] reg_val;
  logic        crc_fb;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;

  assign in_xfer    = in_valid && in_ready;
  assign cnt_inc    = cnt_r + 4'd1;
  assign frame_done = (cnt_inc >= 4'(SHORT_LEN)) &&
                      ((frame_r[1] != FN_WRITE) || (cnt_inc == 4'(LONG_LEN)));
  assign addr_ok     = (frame_r[0] == slave_r);
  assign start_read  = in_xfer && frame_done && addr_ok && (frame_r[1] == FN_READ);
  assign start_write = in_xfer && frame_done && addr_ok && (frame_r[1] == FN_WRITE);
  assign slot_free   = !out_valid_r || out_ready;
  assign n_data      = is_read_r ? READ_DATA : WRITE_DATA;
  assign crc_fb      = crc_r[0] ^ sh_r[0];

  // byte k of the reply body
  always_comb begin
    j       = k_r - 8'd3;
    reg_idx = {1'b0, j[7:1]};
    reg_val = is_target(reg_idx) ? hreg_r[slot_of(reg_idx)] : 16'h0000;
    if (k_r == 8'd0) begin
      data_byte = slave_r;
    end else if (k_r == 8'd1) begin
      data_byte = is_read_r ? FN_READ : FN_WRITE;
    end else if (!is_read_r) begin
      data_byte = frame_r[{1'b0, k_r[2:0]}];
    end else if (k_r == 8'd2) begin
      data_byte = BYTE_CNT;
    end else begin
      data_byte = j[0] ? reg_val[7:0] : reg_val[15:8];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_read || start_write) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          if (k_r < n_data) state_nxt = ST_CRC;
          else if (k_r != n_data) state_nxt = ST_IDLE;
        end
      end
      ST_CRC: begin
        if (bit_r == 3'd7) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    cnt_nxt       = cnt_r;
    frame_nxt     = frame_r;
    hreg_nxt      = hreg_r;
    slave_nxt     = cfg_wr_en ? cfg_wr_data : slave_r;
    crc_nxt       = crc_r;
    sh_nxt        = sh_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    is_read_nxt   = is_read_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cnt_r < 4'(FRAME_KEEP)) frame_nxt[cnt_r] = in_rx_byte;
          cnt_nxt = frame_done ? 4'd0 : cnt_inc;
          if (start_write && is_target(frame_r[3]) && (int'(frame_r[3]) < NUM_REGS)) begin
            hreg_nxt[slot_of(frame_r[3])] = {frame_r[7], frame_r[8]};
          end
          if (start_read || start_write) begin
            crc_nxt     = CRC_INIT;
            k_nxt       = 8'd0;
            is_read_nxt = start_read;
          end
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          k_nxt         = k_r + 8'd1;
          if (k_r < n_data) begin
            out_byte_nxt = data_byte;
            sh_nxt       = data_byte;
            bit_nxt      = 3'd0;
          end else if (k_r == n_data) begin
            out_byte_nxt = crc_r[7:0];
          end else begin
            out_byte_nxt = crc_r[15:8];
            out_last_nxt = 1'b1;
          end
        end
      end
      ST_CRC: begin
        // reflected crc, one data bit per cycle, lsb first
        crc_nxt = {1'b0, crc_r[15:1]} ^ (crc_fb ? CRC_POLY : 16'h0000);
        sh_nxt  = {1'b0, sh_r[7:1]};
        bit_nxt = bit_r + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      hreg_r      <= '{default: 16'h0000};
      slave_r     <= 8'd1;
      crc_r       <= CRC_INIT;
      bit_r       <= 3'd0;
      k_r         <= 8'd0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hreg_r      <= hreg_nxt;
      slave_r     <= slave_nxt;
      crc_r       <= crc_nxt;
      bit_r       <= bit_nxt;
      k_r         <= k_nxt;
      is_read_r   <= is_read_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    sh_r       <= sh_nxt;
    out_byte_r <= out_byte_nxt;
  end

  `MRS_ASSERT_IMP(a_last_ends_reply, clk, rst_n, $rose(out_last_r), state_r == ST_IDLE)
  `MRS_ASSERT_NXT(a_crc_eight_bits, clk, rst_n, (state_r == ST_CRC) && (bit_r == 3'd7), state_r == ST_LOAD)
  `MRS_ASSERT_NXT(a_crc_starts_clean, clk, rst_n, (state_r == ST_LOAD) && (state_nxt == ST_CRC), (bit_r == 3'd0) && out_valid_r && !out_last_r)

endmodule
